// ===== rtl/nrh_pkg.sv =====
// shared types, constants and register codes for the normalized range histogram
// no dependencies; imported by every other file of the block
package nrh_pkg;

    localparam int MAX_CLASSES_DEF  = 64;
    localparam int COUNT_WIDTH_DEF  = 32;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // fixed field widths
    localparam int BOUND_W    = 16;
    localparam int CLASS_W    = 7;
    localparam int BIN_IDX_W  = 6;
    localparam int FRAC_W     = 17;
    localparam int FRAC_SHIFT = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // bin divider retires this many quotient bits per cycle
    localparam int BIN_STEP_BITS = 4;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1 << FRAC_SHIFT);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS = 2'd2;

    localparam logic signed [BOUND_W-1:0] LOW_RST   = 16'sd0;
    localparam logic signed [BOUND_W-1:0] HIGH_RST  = 16'sd32767;
    localparam logic [CLASS_W-1:0]        CLASS_RST = 7'd16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BIN,
        ST_BIN_WAIT,
        ST_RD,
        ST_UPD,
        ST_EM_RD,
        ST_EM_DIV,
        ST_EM_WAIT,
        ST_EM_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/nrh_if.sv =====
// valid/ready channel interfaces: sample input, bin result output, register writes
// depends on nrh_pkg for field widths
interface nrh_in_if
    import nrh_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] pixel_value;
    logic                           final_pixel;

    modport source (output valid, output pixel_value, output final_pixel, input ready);
    modport sink   (input valid, input pixel_value, input final_pixel, output ready);
endinterface

interface nrh_out_if
    import nrh_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BIN_IDX_W-1:0] bin_index;
    logic [FRAC_W-1:0]    bin_fraction;
    logic                 no_samples;
    logic                 final_bin;

    modport source (output valid, output bin_index, output bin_fraction,
                    output no_samples, output final_bin, input ready);
    modport sink   (input valid, input bin_index, input bin_fraction,
                    input no_samples, input final_bin, output ready);
endinterface

interface nrh_cfg_if
    import nrh_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== rtl/normalized_range_histogram_unit.sv =====
// normalized range histogram: top level with control sequencer and config registers
// depends on nrh_pkg, nrh_if, nrh_ram and nrh_div
//
// usage:
//   i_pix  : sample items (pixel_value, final_pixel), one at a time
//   o_res  : bin result items (bin_index, bin_fraction, no_samples, final_bin)
//   i_cfg  : register writes, index 0 low bound, 1 high bound, 2 class count;
//            always ready, write only while no image is in flight
// bin counters live in a ram; each sample is a read-modify-write of one bin.
// an in-range sample is accepted, set up, binned by the radix-16 bin divider,
// then read from the ram and written back; with equal bounds the divider is
// skipped, and an out-of-range sample only passes accept and setup.
// on a final sample, after its own update, one item per bin in use follows:
// ram read, fraction setup, the bit-serial fraction divider (skipped when the
// total is zero) and an output state that waits for o_res ready. the next
// sample is taken after the last bin item is delivered.
// o_res holds its payload while the receiver stalls; nothing is lost.
// reset clears the counters at once through per-bin valid bits and loads the
// register defaults (0, 32767, 16).
module normalized_range_histogram_unit
    import nrh_pkg::*;
#(
    parameter int MAX_CLASSES  = MAX_CLASSES_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nrh_in_if.sink    i_pix,
    nrh_out_if.source o_res,
    nrh_cfg_if.sink   i_cfg
);

    localparam int IDX_W  = $clog2(MAX_CLASSES);
    localparam int CLS_W  = $clog2(MAX_CLASSES + 1);
    localparam int CC_W   = (CLS_W > CLASS_W) ? CLS_W : CLASS_W;
    localparam int EXT_W  = ((SAMPLE_WIDTH > BOUND_W) ? SAMPLE_WIDTH : BOUND_W) + 1;
    localparam int PROD_W = BOUND_W + CLS_W;
    localparam int FNUM_W = COUNT_WIDTH + FRAC_SHIFT;

    t_state r_state, n_state;

    logic signed [BOUND_W-1:0] r_low;
    logic signed [BOUND_W-1:0] r_high;
    logic [CLASS_W-1:0]        r_class;

    logic [BOUND_W-1:0]     r_off;
    logic                   r_inr;
    logic                   r_last;
    logic [IDX_W-1:0]       r_bin;
    logic [IDX_W-1:0]       r_idx;
    logic [MAX_CLASSES-1:0] r_valid;
    logic [COUNT_WIDTH-1:0] r_total;
    logic [FRAC_W-1:0]      r_frac;

    logic [CC_W-1:0]  cc_ext;
    logic [CLS_W-1:0] eff;

    logic signed [EXT_W-1:0] s_ext, low_ext, high_ext, off_full, span_full;
    logic [BOUND_W-1:0]      span;
    logic                    in_range;
    logic                    span_zero;
    logic [PROD_W-1:0]       prod;

    logic             pix_ready;
    logic             res_valid;
    logic             bdiv_start;
    logic             fdiv_start;
    t_div_stat        bdiv_stat;
    t_div_stat        fdiv_stat;
    logic [CLS_W-1:0] bdiv_quo;
    logic [CLS_W-1:0] bin_q;
    logic [FRAC_W-1:0] fdiv_quo;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] old_count;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic                   last_bin;
    logic                   res_fire;

    // bins in use: zero acts as one, large values stop at the table size
    always_comb begin
        cc_ext = CC_W'(r_class);
        if (cc_ext == '0) begin
            eff = CLS_W'(1);
        end else if (cc_ext > CC_W'(MAX_CLASSES)) begin
            eff = CLS_W'(MAX_CLASSES);
        end else begin
            eff = CLS_W'(cc_ext);
        end
    end

    assign s_ext     = EXT_W'($signed(i_pix.pixel_value));
    assign low_ext   = EXT_W'(r_low);
    assign high_ext  = EXT_W'(r_high);
    assign off_full  = s_ext - low_ext;
    assign span_full = high_ext - low_ext;
    assign span      = span_full[BOUND_W-1:0];
    assign span_zero = (span == '0);
    assign in_range  = (s_ext >= low_ext) && (s_ext <= high_ext);
    assign prod      = PROD_W'(r_off) * PROD_W'(eff);

    assign bin_q     = (bdiv_quo >= eff) ? (eff - CLS_W'(1)) : bdiv_quo;
    assign old_count = r_valid[r_bin] ? ram_rdata : '0;
    assign ram_wdata = (old_count == {COUNT_WIDTH{1'b1}}) ? old_count
                                                          : old_count + COUNT_WIDTH'(1);
    assign cur_count = r_valid[r_idx] ? ram_rdata : '0;
    assign last_bin  = ((CLS_W'(r_idx) + CLS_W'(1)) == eff);
    assign res_fire  = res_valid && o_res.ready;

    nrh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_CLASSES)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_bin),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    nrh_div #(
        .NUM_W     (PROD_W),
        .DEN_W     (BOUND_W),
        .QUO_W     (CLS_W),
        .STEP_BITS (BIN_STEP_BITS)
    ) u_bin_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bdiv_start),
        .i_num   (prod),
        .i_den   (span),
        .o_stat  (bdiv_stat),
        .o_quo   (bdiv_quo)
    );

    nrh_div #(
        .NUM_W     (FNUM_W),
        .DEN_W     (COUNT_WIDTH),
        .QUO_W     (FRAC_W),
        .STEP_BITS (1)
    ) u_frac_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fdiv_start),
        .i_num   ({cur_count, {FRAC_SHIFT{1'b0}}}),
        .i_den   (r_total),
        .o_stat  (fdiv_stat),
        .o_quo   (fdiv_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_pix.valid) begin
                    n_state = ST_BIN;
                end
            end
            ST_BIN: begin
                if (!r_inr) begin
                    n_state = r_last ? ST_EM_RD : ST_IDLE;
                end else if (span_zero) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_BIN_WAIT;
                end
            end
            ST_BIN_WAIT: begin
                if (bdiv_stat.done) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                n_state = r_last ? ST_EM_RD : ST_IDLE;
            end
            ST_EM_RD: begin
                n_state = ST_EM_DIV;
            end
            ST_EM_DIV: begin
                n_state = (r_total == '0) ? ST_EM_OUT : ST_EM_WAIT;
            end
            ST_EM_WAIT: begin
                if (fdiv_stat.done) begin
                    n_state = ST_EM_OUT;
                end
            end
            ST_EM_OUT: begin
                if (o_res.ready) begin
                    n_state = last_bin ? ST_IDLE : ST_EM_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        pix_ready  = 1'b0;
        res_valid  = 1'b0;
        bdiv_start = 1'b0;
        fdiv_start = 1'b0;
        ram_we     = 1'b0;
        ram_raddr  = r_bin;
        case (r_state)
            ST_IDLE: begin
                pix_ready = 1'b1;
            end
            ST_BIN: begin
                bdiv_start = r_inr && !span_zero;
            end
            ST_UPD: begin
                ram_we = 1'b1;
            end
            ST_EM_RD: begin
                ram_raddr = r_idx;
            end
            ST_EM_DIV: begin
                fdiv_start = (r_total != '0);
            end
            ST_EM_OUT: begin
                res_valid = 1'b1;
            end
            default: begin
                pix_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_low   <= LOW_RST;
            r_high  <= HIGH_RST;
            r_class <= CLASS_RST;
            r_valid <= '0;
            r_total <= '0;
            r_idx   <= '0;
            r_inr   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.reg_index)
                    CFG_LOW:   r_low   <= $signed(i_cfg.reg_data[BOUND_W-1:0]);
                    CFG_HIGH:  r_high  <= $signed(i_cfg.reg_data[BOUND_W-1:0]);
                    CFG_CLASS: r_class <= i_cfg.reg_data[CLASS_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    r_idx <= '0;
                    if (i_pix.valid) begin
                        r_inr  <= in_range;
                        r_last <= i_pix.final_pixel;
                    end
                end
                ST_UPD: begin
                    r_valid[r_bin] <= 1'b1;
                    if (r_total != {COUNT_WIDTH{1'b1}}) begin
                        r_total <= r_total + COUNT_WIDTH'(1);
                    end
                end
                ST_EM_OUT: begin
                    if (o_res.ready) begin
                        if (last_bin) begin
                            r_valid <= '0;
                            r_total <= '0;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                // offset fits 16 bits whenever the sample is in range
                r_off <= off_full[BOUND_W-1:0];
            end
            ST_BIN: begin
                r_bin <= '0;
            end
            ST_BIN_WAIT: begin
                if (bdiv_stat.done) begin
                    r_bin <= bin_q[IDX_W-1:0];
                end
            end
            ST_EM_DIV: begin
                r_frac <= '0;
            end
            ST_EM_WAIT: begin
                if (fdiv_stat.done) begin
                    r_frac <= (fdiv_quo > FRAC_ONE) ? FRAC_ONE : fdiv_quo;
                end
            end
            default: ;
        endcase
    end

    assign i_pix.ready        = pix_ready;
    assign i_cfg.ready        = 1'b1;
    assign o_res.valid        = res_valid;
    assign o_res.bin_index    = BIN_IDX_W'(r_idx);
    assign o_res.bin_fraction = r_frac;
    assign o_res.no_samples   = (r_total == '0);
    assign o_res.final_bin    = last_bin;

    // counters are clear once the last bin item of a run has gone out
    a_clear_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_fire && last_bin) |=> (r_total == '0 && r_valid == '0))
        else $error("counters not cleared after last bin item");

    // no sample is taken while either divider is working
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bdiv_stat.busy || fdiv_stat.busy) |-> !pix_ready)
        else $error("sample accepted while a divider is busy");

    // an empty histogram reports zero fractions
    a_zero_fraction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && o_res.no_samples) |-> (o_res.bin_fraction == '0))
        else $error("nonzero fraction with zero total");

    // bin updates stay inside the bins in use
    a_bin_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (CLS_W'(r_bin) < eff))
        else $error("bin update outside the bins in use");

endmodule

// ===== rtl/nrh_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// depends on nrh_pkg for default sizes
module nrh_ram
    import nrh_pkg::*;
#(
    parameter int WIDTH = COUNT_WIDTH_DEF,
    parameter int DEPTH = MAX_CLASSES_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/nrh_div.sv =====
// iterative unsigned divider for quotients known to fit in QUO_W bits
// depends on nrh_pkg for the status struct
module nrh_div
    import nrh_pkg::*;
#(
    parameter int NUM_W     = 48,
    parameter int DEN_W     = 32,
    parameter int QUO_W     = FRAC_W,
    parameter int STEP_BITS = 1,
    localparam int ITER     = (QUO_W + STEP_BITS - 1) / STEP_BITS,
    localparam int QP       = ITER * STEP_BITS,
    localparam int EXT_W    = NUM_W + QP + DEN_W,
    localparam int CNT_W    = $clog2(ITER + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_stat        o_stat,
    output logic [QUO_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem,  n_rem;
    logic [QP-1:0]    r_low,  n_low;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [EXT_W-1:0] num_ext;

    assign num_ext = EXT_W'(i_num);

    // restoring steps, one quotient bit shifted into the low word per step
    always_comb begin
        logic [DEN_W:0] t;
        logic           ge;
        n_rem = r_rem;
        n_low = r_low;
        for (int k = 0; k < STEP_BITS; k++) begin
            t  = {n_rem, n_low[QP-1]};
            ge = (t >= {1'b0, r_den});
            if (ge) begin
                t = t - {1'b0, r_den};
            end
            n_rem = t[DEN_W-1:0];
            n_low = {n_low[QP-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // upper part is below the divisor since the quotient fits in QP bits
            r_rem <= num_ext[QP +: DEN_W];
            r_low <= num_ext[QP-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= n_low;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_low[QUO_W-1:0];

endmodule
